// File: sv/coherency_jones_transform_top_defines.svh
// coherency_jones_transform_top_defines.svh: assertion macros for the transform checker
// expects signals named clk and arst_n in the scope where a macro is used
`ifndef COHERENCY_JONES_TRANSFORM_TOP_DEFINES_SVH
`define COHERENCY_JONES_TRANSFORM_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CJT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cjt checker: same-cycle check failed");

// next-cycle implication, disabled during reset
`define CJT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cjt checker: next-cycle check failed");

`endif

// File: sv/cjt_pkg.sv
// cjt_pkg: widths, register codes and types for the coherency transform
// no dependencies; used by the top level and its checker
package cjt_pkg;

	// data in Q16.16, coefficients in Q4.28 at the default widths
	localparam int DATA_WIDTH = 32;
	localparam int COEF_WIDTH = 32;
	localparam int CFRAC      = COEF_WIDTH - 4;

	// stream packing
	localparam int NUM_FIELDS = 4;
	localparam int FLDS_W     = NUM_FIELDS * DATA_WIDTH;
	localparam int TDATA_W    = ((FLDS_W + 7) / 8) * 8;
	localparam int TUSER_W    = 1;

	// field positions inside tdata, lowest first
	localparam int FLD_PP = 0;
	localparam int FLD_QQ = 1;
	localparam int FLD_XR = 2;
	localparam int FLD_XI = 3;

	// configuration registers
	localparam int NUM_REGS  = 8;
	localparam int RIDX_W    = $clog2(NUM_REGS);
	localparam int CFG_IDX_W = RIDX_W + 1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_00_RE = CFG_IDX_W'(0);
	localparam cfg_idx_t REG_00_IM = CFG_IDX_W'(1);
	localparam cfg_idx_t REG_01_RE = CFG_IDX_W'(2);
	localparam cfg_idx_t REG_01_IM = CFG_IDX_W'(3);
	localparam cfg_idx_t REG_10_RE = CFG_IDX_W'(4);
	localparam cfg_idx_t REG_10_IM = CFG_IDX_W'(5);
	localparam cfg_idx_t REG_11_RE = CFG_IDX_W'(6);
	localparam cfg_idx_t REG_11_IM = CFG_IDX_W'(7);

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [COEF_WIDTH-1:0] coef_t;

	localparam coef_t COEF_ONE = coef_t'(64'd1 << CFRAC);

	// datapath widths
	localparam int P1_W  = DATA_WIDTH + COEF_WIDTH;   // data x coef product
	localparam int S1_W  = P1_W + 2;                  // sum of three products
	localparam int M_W   = S1_W - CFRAC;              // intermediate J*C element
	localparam int MLO_W = 16;                        // low slice of M for split multiply
	localparam int MHI_W = M_W - MLO_W;
	localparam int HP_W  = MHI_W + COEF_WIDTH;
	localparam int HS_W  = HP_W + 2;
	localparam int LP_W  = MLO_W + 1 + COEF_WIDTH;
	localparam int LS_W  = LP_W + 2;
	localparam int T_W   = M_W + COEF_WIDTH + 3;      // full second-stage sum
	localparam int R_W   = T_W - CFRAC;
	localparam int DP_W  = 2 * COEF_WIDTH;            // determinant product
	localparam int DS_W  = DP_W + 2;

	// result element order, equals output field order
	localparam int OUT_PP = 0;
	localparam int OUT_QQ = 1;
	localparam int OUT_XR = 2;
	localparam int OUT_XI = 3;

endpackage

// File: sv/coherency_jones_transform_top.sv
// coherency_jones_transform_top: J*C*J^H congruence transform of one coherency bin per cycle
// while the output is not stalled; depends on cjt_pkg
// Usage:
//   s_axis: one bin per transfer; tdata holds pp_power, qq_power, cross_real,
//   cross_imag (32 bits each, lowest first). m_axis: one result per input;
//   tdata holds out_pp_power, out_qq_power, out_cross_real, out_cross_imag,
//   tuser holds zero_response.
//   cfg: write port for the eight response registers (index 0..7); always
//   ready, writes to other indexes are dropped. Write only while the
//   pipeline is empty.
// Pipeline: five register stages (products, J*C sums, split partial products,
//   partial sums, shift and saturate).
// Throughput: one bin per cycle unless the output stalls; every multiply stage
//   then holds a new item each cycle. The registered determinant check runs off
//   the config registers, so a bin may follow a config write in the next cycle.
// Reset: pipeline empty, J set to identity (determinant nonzero).
// Stall: each stage advances when empty or when the next one advances, so
//   bubbles close up; with the output held, up to five bins sit in the pipe
//   before s_axis_tready drops. Nothing is lost or repeated.
module coherency_jones_transform_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// pp_power, qq_power, cross_real, cross_imag
	input  logic [cjt_pkg::TDATA_W-1:0]   s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_pp_power, out_qq_power, out_cross_real, out_cross_imag
	output logic [cjt_pkg::TDATA_W-1:0]   m_axis_tdata,
	// zero_response
	output logic [cjt_pkg::TUSER_W-1:0]   m_axis_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cjt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cjt_pkg::COEF_WIDTH-1:0] cfg_data
);
	import cjt_pkg::*;

	function automatic logic signed [P1_W-1:0] mul_dc(data_t d, coef_t c);
		return P1_W'(d) * P1_W'(c);
	endfunction

	function automatic logic signed [DP_W-1:0] mul_cc(coef_t a, coef_t b);
		return DP_W'(a) * DP_W'(b);
	endfunction

	// response registers
	coef_t resp_q [NUM_REGS];
	coef_t j_re [4];
	coef_t j_im [4];

	// determinant check
	logic signed [DP_W-1:0] det_p_q [8];
	logic signed [DS_W-1:0] det_re;
	logic signed [DS_W-1:0] det_im;
	logic                   det_zero_q;

	// handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// datapath
	data_t                   in_f [NUM_FIELDS];
	logic [FLDS_W-1:0]       raw_s1, raw_s2, raw_s3, raw_s4;
	logic signed [P1_W-1:0]  prod_s1 [2][12];
	logic signed [M_W-1:0]   m_re_d [4];
	logic signed [M_W-1:0]   m_im_d [4];
	logic signed [M_W-1:0]   m_re_s2 [4];
	logic signed [M_W-1:0]   m_im_s2 [4];
	logic signed [M_W-1:0]   mop [4][4];
	coef_t                   cop [4][4];
	logic signed [HP_W-1:0]  hp_s3 [4][4];
	logic signed [LP_W-1:0]  lp_s3 [4][4];
	logic signed [HS_W-1:0]  hs_d [4];
	logic signed [LS_W-1:0]  ls_d [4];
	logic signed [HS_W-1:0]  hs_s4 [4];
	logic signed [LS_W-1:0]  ls_s4 [4];
	data_t                   sat_d [4];
	logic [FLDS_W-1:0]       out_s5;
	logic                    zero_s5;

	// config write port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// identity response
			for (int i = 0; i < NUM_REGS; i++) begin
				if (i == int'(REG_00_RE) || i == int'(REG_11_RE)) begin
					resp_q[i] <= COEF_ONE;
				end else begin
					resp_q[i] <= '0;
				end
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index) inside
				REG_00_RE, REG_00_IM, REG_01_RE, REG_01_IM,
				REG_10_RE, REG_10_IM, REG_11_RE, REG_11_IM: begin
					resp_q[cfg_index[RIDX_W-1:0]] <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	// element e of J: 0 = row0 col0, 1 = row0 col1, 2 = row1 col0, 3 = row1 col1
	always_comb begin
		for (int e = 0; e < 4; e++) begin
			j_re[e] = resp_q[2*e];
			j_im[e] = resp_q[2*e+1];
		end
	end

	// determinant products, a = J00, b = J01, c = J10, d = J11
	always_ff @(posedge clk) begin
		det_p_q[0] <= mul_cc(j_re[0], j_re[3]);
		det_p_q[1] <= mul_cc(j_im[0], j_im[3]);
		det_p_q[2] <= mul_cc(j_re[1], j_re[2]);
		det_p_q[3] <= mul_cc(j_im[1], j_im[2]);
		det_p_q[4] <= mul_cc(j_re[0], j_im[3]);
		det_p_q[5] <= mul_cc(j_im[0], j_re[3]);
		det_p_q[6] <= mul_cc(j_re[1], j_im[2]);
		det_p_q[7] <= mul_cc(j_im[1], j_re[2]);
	end

	assign det_re = DS_W'(det_p_q[0]) - DS_W'(det_p_q[1])
		- DS_W'(det_p_q[2]) + DS_W'(det_p_q[3]);
	assign det_im = DS_W'(det_p_q[4]) + DS_W'(det_p_q[5])
		- DS_W'(det_p_q[6]) - DS_W'(det_p_q[7]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_zero_q <= 1'b0;
		end else begin
			det_zero_q <= (det_re == '0) && (det_im == '0);
		end
	end

	// stage enables: a stage moves when empty or when its successor moves
	assign en_s5 = !v_s5 || m_axis_tready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// input fields
	always_comb begin
		for (int f = 0; f < NUM_FIELDS; f++) begin
			in_f[f] = s_axis_tdata[f*DATA_WIDTH +: DATA_WIDTH];
		end
	end

	// stage 1: the twelve products of each row of J*C
	always_ff @(posedge clk) begin
		if (en_s1) begin
			raw_s1 <= s_axis_tdata[FLDS_W-1:0];
			for (int r = 0; r < 2; r++) begin
				prod_s1[r][0]  <= mul_dc(in_f[FLD_PP], j_re[2*r]);
				prod_s1[r][1]  <= mul_dc(in_f[FLD_XR], j_re[2*r+1]);
				prod_s1[r][2]  <= mul_dc(in_f[FLD_XI], j_im[2*r+1]);
				prod_s1[r][3]  <= mul_dc(in_f[FLD_PP], j_im[2*r]);
				prod_s1[r][4]  <= mul_dc(in_f[FLD_XI], j_re[2*r+1]);
				prod_s1[r][5]  <= mul_dc(in_f[FLD_XR], j_im[2*r+1]);
				prod_s1[r][6]  <= mul_dc(in_f[FLD_XR], j_re[2*r]);
				prod_s1[r][7]  <= mul_dc(in_f[FLD_XI], j_im[2*r]);
				prod_s1[r][8]  <= mul_dc(in_f[FLD_QQ], j_re[2*r+1]);
				prod_s1[r][9]  <= mul_dc(in_f[FLD_XI], j_re[2*r]);
				prod_s1[r][10] <= mul_dc(in_f[FLD_XR], j_im[2*r]);
				prod_s1[r][11] <= mul_dc(in_f[FLD_QQ], j_im[2*r+1]);
			end
		end
	end

	// stage 2: M = J*C, exact sums then floor shift to the data format
	always_comb begin
		logic signed [S1_W-1:0] sum_re0, sum_im0, sum_re1, sum_im1;
		for (int r = 0; r < 2; r++) begin
			sum_re0 = S1_W'(prod_s1[r][0]) + S1_W'(prod_s1[r][1]) - S1_W'(prod_s1[r][2]);
			sum_im0 = S1_W'(prod_s1[r][3]) + S1_W'(prod_s1[r][4]) + S1_W'(prod_s1[r][5]);
			sum_re1 = S1_W'(prod_s1[r][6]) + S1_W'(prod_s1[r][7]) + S1_W'(prod_s1[r][8]);
			sum_im1 = S1_W'(prod_s1[r][10]) + S1_W'(prod_s1[r][11]) - S1_W'(prod_s1[r][9]);
			m_re_d[2*r]   = M_W'(sum_re0 >>> CFRAC);
			m_im_d[2*r]   = M_W'(sum_im0 >>> CFRAC);
			m_re_d[2*r+1] = M_W'(sum_re1 >>> CFRAC);
			m_im_d[2*r+1] = M_W'(sum_im1 >>> CFRAC);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			raw_s2  <= raw_s1;
			m_re_s2 <= m_re_d;
			m_im_s2 <= m_im_d;
		end
	end

	// operand pairs of M*J^H for each result element (row r, col s)
	always_comb begin
		int ro, so;
		for (int o = 0; o < 4; o++) begin
			ro = (o == OUT_QQ || o == OUT_XI) ? 1 : 0;
			so = (o == OUT_QQ || o == OUT_XR) ? 1 : 0;
			for (int k = 0; k < 2; k++) begin
				if (o == OUT_XI) begin
					// imaginary part: M.im*J.re - M.re*J.im
					mop[o][2*k]   = m_im_s2[2*ro+k];
					cop[o][2*k]   = j_re[2*so+k];
					mop[o][2*k+1] = m_re_s2[2*ro+k];
					cop[o][2*k+1] = j_im[2*so+k];
				end else begin
					// real part: M.re*J.re + M.im*J.im
					mop[o][2*k]   = m_re_s2[2*ro+k];
					cop[o][2*k]   = j_re[2*so+k];
					mop[o][2*k+1] = m_im_s2[2*ro+k];
					cop[o][2*k+1] = j_im[2*so+k];
				end
			end
		end
	end

	// stage 3: split multiply, signed high slice and unsigned low slice of M
	always_ff @(posedge clk) begin
		if (en_s3) begin
			raw_s3 <= raw_s2;
			for (int o = 0; o < 4; o++) begin
				for (int t = 0; t < 4; t++) begin
					hp_s3[o][t] <= HP_W'($signed(mop[o][t][M_W-1:MLO_W])) * HP_W'(cop[o][t]);
					lp_s3[o][t] <= LP_W'($signed({1'b0, mop[o][t][MLO_W-1:0]}))
						* LP_W'(cop[o][t]);
				end
			end
		end
	end

	// stage 4: sum the partial products of each element
	always_comb begin
		for (int o = 0; o < 4; o++) begin
			hs_d[o] = '0;
			ls_d[o] = '0;
			for (int t = 0; t < 4; t++) begin
				if (o == OUT_XI && t % 2 == 1) begin
					hs_d[o] = hs_d[o] - HS_W'(hp_s3[o][t]);
					ls_d[o] = ls_d[o] - LS_W'(lp_s3[o][t]);
				end else begin
					hs_d[o] = hs_d[o] + HS_W'(hp_s3[o][t]);
					ls_d[o] = ls_d[o] + LS_W'(lp_s3[o][t]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			raw_s4 <= raw_s3;
			hs_s4  <= hs_d;
			ls_s4  <= ls_d;
		end
	end

	// stage 5: recombine, floor shift, saturate
	always_comb begin
		logic signed [T_W-1:0] tot;
		logic signed [R_W-1:0] rf;
		for (int o = 0; o < 4; o++) begin
			tot = (T_W'(hs_s4[o]) <<< MLO_W) + T_W'(ls_s4[o]);
			rf  = R_W'(tot >>> CFRAC);
			if ((&rf[R_W-1:DATA_WIDTH-1]) || !(|rf[R_W-1:DATA_WIDTH-1])) begin
				sat_d[o] = rf[DATA_WIDTH-1:0];
			end else if (rf[R_W-1]) begin
				sat_d[o] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
			end else begin
				sat_d[o] = {1'b0, {(DATA_WIDTH-1){1'b1}}};
			end
		end
	end

	// output register, singular response passes the bin through
	always_ff @(posedge clk) begin
		if (en_s5) begin
			zero_s5 <= det_zero_q;
			for (int o = 0; o < 4; o++) begin
				out_s5[o*DATA_WIDTH +: DATA_WIDTH] <= det_zero_q
					? raw_s4[o*DATA_WIDTH +: DATA_WIDTH] : sat_d[o];
			end
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = TDATA_W'(out_s5);
	assign m_axis_tuser  = TUSER_W'(zero_s5);

endmodule

// File: sv/cjt_checker.sv
// cjt_checker: port-level assertions for coherency_jones_transform_top, bound to the top
// depends on cjt_pkg and coherency_jones_transform_top_defines.svh
`include "coherency_jones_transform_top_defines.svh"

module cjt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [cjt_pkg::TDATA_W-1:0]   m_axis_tdata,
	input logic [cjt_pkg::TUSER_W-1:0]   m_axis_tuser,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);

	// a stalled result stays offered
	`CJT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// a stalled result keeps its value
	`CJT_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// with the output register empty every stage can move, so input is open
	`CJT_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

	// config writes are never back-pressured
	`CJT_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind coherency_jones_transform_top cjt_checker u_cjt_checker (.*);

// File: tb/tb_coherency_jones_transform_top.sv
// tb_coherency_jones_transform_top: self-checking bench for the J*C*J^H coherency transform
// depends on cjt_pkg and coherency_jones_transform_top; predicts every bin with exact
// wide integer arithmetic and checks each m_axis transfer against the oldest prediction
`timescale 1ns / 100ps

module tb_coherency_jones_transform_top;
	import cjt_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		data_t pp;
		data_t qq;
		data_t xr;
		data_t xi;
		logic  zero;
	} bin_t;

	localparam data_t DATA_MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t DATA_MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam coef_t COEF_MAX_V = {1'b0, {(COEF_WIDTH-1){1'b1}}};
	localparam coef_t COEF_MIN_V = {1'b1, {(COEF_WIDTH-1){1'b0}}};
	localparam coef_t COEF_HALF  = COEF_ONE >>> 1;
	localparam wide_t SAT_HI     = (wide_t'(1) <<< (DATA_WIDTH-1)) - 1;
	localparam wide_t SAT_LO     = -SAT_HI - 1;

	// indexes past the register list, writes there must be dropped
	localparam cfg_idx_t IDX_PAST_END = cfg_idx_t'(NUM_REGS);
	localparam cfg_idx_t IDX_TOP      = '1;

	localparam int RAND_SETTINGS    = 8;
	localparam int BINS_PER_SETTING = 180;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [TDATA_W-1:0]    m_axis_tdata;
	logic [TUSER_W-1:0]    m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [COEF_WIDTH-1:0] cfg_data;

	// response matrix as the block holds it, and the next one to load
	coef_t resp_regs [NUM_REGS];
	coef_t resp_next [NUM_REGS];

	bin_t transformed_bins [$];

	int send_idle_pct;
	int recv_stall_pct;
	int n_sent;
	int n_checked;
	int n_singular;
	int n_settings;
	int n_errors;

	coherency_jones_transform_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic data_t clamp_data(wide_t v);
		if (v > SAT_HI)
			return data_t'(SAT_HI);
		if (v < SAT_LO)
			return data_t'(SAT_LO);
		return data_t'(v);
	endfunction

	// exact R = J*C*J^H with floor shift after each stage, saturation at the end
	function automatic bin_t transform_bin(data_t pp, data_t qq, data_t xr, data_t xi);
		wide_t jr [4];
		wide_t ji [4];
		wide_t cr [4];
		wide_t ci [4];
		wide_t mr [4];
		wide_t mi [4];
		wide_t rr [4];
		wide_t ri [4];
		wide_t acc_re;
		wide_t acc_im;
		wide_t det_re;
		wide_t det_im;
		bin_t  res;
		for (int e = 0; e < 4; e++) begin
			jr[e] = resp_regs[e*2];
			ji[e] = resp_regs[e*2+1];
		end
		det_re = jr[0]*jr[3] - ji[0]*ji[3] - jr[1]*jr[2] + ji[1]*ji[2];
		det_im = jr[0]*ji[3] + ji[0]*jr[3] - jr[1]*ji[2] - ji[1]*jr[2];
		// singular response: bin passes untouched
		if (det_re == 0 && det_im == 0) begin
			res.pp   = pp;
			res.qq   = qq;
			res.xr   = xr;
			res.xi   = xi;
			res.zero = 1'b1;
			return res;
		end
		// hermitian coherency matrix
		cr[0] = pp;
		ci[0] = 0;
		cr[1] = xr;
		ci[2] = xi;
		ci[1] = -ci[2];
		cr[2] = xr;
		cr[3] = qq;
		ci[3] = 0;
		// first stage M = J*C, kept wide
		for (int r = 0; r < 2; r++)
			for (int s = 0; s < 2; s++) begin
				acc_re = 0;
				acc_im = 0;
				for (int k = 0; k < 2; k++) begin
					acc_re = acc_re + jr[r*2+k]*cr[k*2+s] - ji[r*2+k]*ci[k*2+s];
					acc_im = acc_im + jr[r*2+k]*ci[k*2+s] + ji[r*2+k]*cr[k*2+s];
				end
				mr[r*2+s] = acc_re >>> CFRAC;
				mi[r*2+s] = acc_im >>> CFRAC;
			end
		// second stage R = M*J^H
		for (int r = 0; r < 2; r++)
			for (int s = 0; s < 2; s++) begin
				acc_re = 0;
				acc_im = 0;
				for (int k = 0; k < 2; k++) begin
					acc_re = acc_re + mr[r*2+k]*jr[s*2+k] + mi[r*2+k]*ji[s*2+k];
					acc_im = acc_im + mi[r*2+k]*jr[s*2+k] - mr[r*2+k]*ji[s*2+k];
				end
				rr[r*2+s] = acc_re >>> CFRAC;
				ri[r*2+s] = acc_im >>> CFRAC;
			end
		res.pp   = clamp_data(rr[0]);
		res.qq   = clamp_data(rr[3]);
		res.xr   = clamp_data(rr[1]);
		res.xi   = clamp_data(ri[2]);
		res.zero = 1'b0;
		return res;
	endfunction

	// mix of full-range words, values near unity and corner values
	function automatic coef_t rand_coef();
		case ($urandom_range(0, 5))
			0, 1: return coef_t'($urandom);
			2, 3, 4: return coef_t'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
			default: begin
				case ($urandom_range(0, 4))
					0: return COEF_MAX_V;
					1: return COEF_MIN_V;
					2: return COEF_ONE;
					3: return -COEF_ONE;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function automatic data_t rand_data();
		case ($urandom_range(0, 5))
			0, 1, 2: return data_t'($urandom);
			3, 4: return data_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			default: begin
				case ($urandom_range(0, 4))
					0: return DATA_MAX_V;
					1: return DATA_MIN_V;
					2: return data_t'(1);
					3: return data_t'(-1);
					default: return '0;
				endcase
			end
		endcase
	endfunction

	// receiver backpressure
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// result checking against the oldest prediction
	always @(posedge clk) begin : check_results
		bin_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (transformed_bins.size() == 0) begin
				$error("result transfer with no bin outstanding");
				n_errors++;
			end else begin
				want = transformed_bins.pop_front();
				n_checked++;
				if (want.zero)
					n_singular++;
				if (data_t'(m_axis_tdata[OUT_PP*DATA_WIDTH +: DATA_WIDTH]) !== want.pp) begin
					$error("out_pp_power: expected %0d, got %0d", want.pp,
						data_t'(m_axis_tdata[OUT_PP*DATA_WIDTH +: DATA_WIDTH]));
					n_errors++;
				end
				if (data_t'(m_axis_tdata[OUT_QQ*DATA_WIDTH +: DATA_WIDTH]) !== want.qq) begin
					$error("out_qq_power: expected %0d, got %0d", want.qq,
						data_t'(m_axis_tdata[OUT_QQ*DATA_WIDTH +: DATA_WIDTH]));
					n_errors++;
				end
				if (data_t'(m_axis_tdata[OUT_XR*DATA_WIDTH +: DATA_WIDTH]) !== want.xr) begin
					$error("out_cross_real: expected %0d, got %0d", want.xr,
						data_t'(m_axis_tdata[OUT_XR*DATA_WIDTH +: DATA_WIDTH]));
					n_errors++;
				end
				if (data_t'(m_axis_tdata[OUT_XI*DATA_WIDTH +: DATA_WIDTH]) !== want.xi) begin
					$error("out_cross_imag: expected %0d, got %0d", want.xi,
						data_t'(m_axis_tdata[OUT_XI*DATA_WIDTH +: DATA_WIDTH]));
					n_errors++;
				end
				if (m_axis_tuser[0] !== want.zero) begin
					$error("zero_response: expected %0b, got %0b", want.zero, m_axis_tuser[0]);
					n_errors++;
				end
			end
		end
	end

	// one bin on s_axis, with random idle cycles ahead of it
	task automatic send_bin(input data_t pp, input data_t qq, input data_t xr, input data_t xi);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {xi, xr, qq, pp};
		do
			@(posedge clk);
		while (!s_axis_tready);
		transformed_bins.push_back(transform_bin(pp, qq, xr, xi));
		n_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input coef_t val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx < NUM_REGS)
			resp_regs[idx] = val;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain the pipe, then write the whole response matrix
	task automatic load_response();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (transformed_bins.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(cfg_idx_t'(i), resp_next[i]);
		end_writes();
		n_settings++;
	endtask

	task automatic set_idling(input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic clear_next();
		for (int i = 0; i < NUM_REGS; i++)
			resp_next[i] = '0;
	endtask

	// identity response after reset: corners of the data fields
	task automatic test_identity();
		set_idling(0, 0);
		send_bin('0, '0, '0, '0);
		send_bin(DATA_MAX_V, DATA_MAX_V, DATA_MAX_V, DATA_MAX_V);
		send_bin(DATA_MIN_V, DATA_MIN_V, DATA_MIN_V, DATA_MIN_V);
		send_bin(DATA_MAX_V, DATA_MIN_V, data_t'(32'h5555_5555), data_t'(32'hAAAA_AAAA));
		send_bin(data_t'(1), data_t'(-1), data_t'(-1), data_t'(1));
	endtask

	// zero determinant: all-zero response and a rank-one response
	task automatic test_singular();
		clear_next();
		load_response();
		send_bin(DATA_MAX_V, DATA_MIN_V, data_t'(32'h1234_5678), data_t'(-32'sd77));
		send_bin(DATA_MIN_V, DATA_MAX_V, DATA_MIN_V, DATA_MAX_V);
		send_bin('0, data_t'(1), '0, data_t'(-1));
		// equal rows make the determinant exactly zero
		resp_next[REG_00_RE] = COEF_ONE;
		resp_next[REG_00_IM] = -COEF_HALF;
		resp_next[REG_01_RE] = COEF_HALF;
		resp_next[REG_01_IM] = COEF_ONE;
		resp_next[REG_10_RE] = COEF_ONE;
		resp_next[REG_10_IM] = -COEF_HALF;
		resp_next[REG_11_RE] = COEF_HALF;
		resp_next[REG_11_IM] = COEF_ONE;
		load_response();
		send_bin(data_t'(32'h0001_0000), data_t'(32'h0002_0000), data_t'(-32'sd5), DATA_MAX_V);
		send_bin(DATA_MIN_V, DATA_MIN_V, DATA_MAX_V, DATA_MIN_V);
	endtask

	// extreme coefficients drive every output into both rails
	task automatic test_saturation();
		clear_next();
		resp_next[REG_00_RE] = COEF_MAX_V;
		resp_next[REG_00_IM] = COEF_MIN_V;
		resp_next[REG_11_RE] = COEF_MIN_V;
		resp_next[REG_11_IM] = COEF_MAX_V;
		load_response();
		send_bin(DATA_MAX_V, DATA_MAX_V, DATA_MAX_V, DATA_MAX_V);
		send_bin(DATA_MIN_V, DATA_MIN_V, DATA_MIN_V, DATA_MIN_V);
		send_bin(DATA_MAX_V, DATA_MIN_V, DATA_MIN_V, DATA_MAX_V);
		send_bin(data_t'(1), data_t'(-1), data_t'(1), data_t'(-1));
		resp_next[REG_00_RE] = COEF_MAX_V;
		resp_next[REG_00_IM] = COEF_MIN_V;
		resp_next[REG_01_RE] = COEF_MIN_V;
		resp_next[REG_01_IM] = COEF_MAX_V;
		resp_next[REG_10_RE] = COEF_MAX_V;
		resp_next[REG_10_IM] = COEF_MAX_V;
		resp_next[REG_11_RE] = COEF_MIN_V;
		resp_next[REG_11_IM] = COEF_MIN_V;
		load_response();
		send_bin(DATA_MAX_V, DATA_MIN_V, DATA_MAX_V, DATA_MIN_V);
		send_bin(DATA_MIN_V, DATA_MAX_V, '0, DATA_MAX_V);
		send_bin(data_t'(32'h0001_0000), data_t'(32'h0001_0000), '0, '0);
	endtask

	// writes past the register list must leave the response alone
	task automatic test_bad_index();
		clear_next();
		resp_next[REG_00_RE] = COEF_ONE;
		resp_next[REG_01_IM] = COEF_HALF >>> 1;
		resp_next[REG_10_RE] = -(COEF_HALF >>> 2);
		resp_next[REG_11_RE] = -COEF_ONE;
		load_response();
		write_reg(IDX_PAST_END, '0);
		write_reg(IDX_TOP, COEF_MAX_V);
		end_writes();
		send_bin(data_t'(32'h0003_0000), data_t'(32'h0001_8000), data_t'(-32'sd65536),
			data_t'(32'h0000_4000));
		send_bin(DATA_MAX_V, '0, DATA_MIN_V, data_t'(12345));
		send_bin(data_t'(-32'sd1000), DATA_MAX_V, data_t'(32'h7FFF_0000), DATA_MIN_V);
	endtask

	// random responses and bins under each idling pattern
	task automatic test_random();
		coef_t a_re;
		coef_t a_im;
		coef_t b_re;
		coef_t b_im;
		for (int s = 0; s < RAND_SETTINGS; s++) begin
			case (s % 4)
				0: set_idling(0, 0);
				1: set_idling(58, 0);
				2: set_idling(0, 58);
				default: set_idling(26, 26);
			endcase
			if (s % 4 == 3) begin
				// rank-one response with random content
				a_re = rand_coef();
				a_im = rand_coef();
				b_re = rand_coef();
				b_im = rand_coef();
				resp_next[REG_00_RE] = a_re;
				resp_next[REG_00_IM] = a_im;
				resp_next[REG_01_RE] = b_re;
				resp_next[REG_01_IM] = b_im;
				resp_next[REG_10_RE] = a_re;
				resp_next[REG_10_IM] = a_im;
				resp_next[REG_11_RE] = b_re;
				resp_next[REG_11_IM] = b_im;
			end else begin
				for (int i = 0; i < NUM_REGS; i++)
					resp_next[i] = rand_coef();
			end
			load_response();
			repeat (BINS_PER_SETTING)
				send_bin(rand_data(), rand_data(), rand_data(), rand_data());
		end
	endtask

	// reset, test sequence and wrap-up
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		for (int i = 0; i < NUM_REGS; i++)
			resp_regs[i] = '0;
		resp_regs[REG_00_RE] = COEF_ONE;
		resp_regs[REG_11_RE] = COEF_ONE;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		n_sent         = 0;
		n_checked      = 0;
		n_singular     = 0;
		n_settings     = 1;
		n_errors       = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_identity();
		test_singular();
		test_saturation();
		test_bad_index();
		test_random();

		// drain
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		for (int w = 0; w < 2000 && transformed_bins.size() != 0; w++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (transformed_bins.size() != 0) begin
			$error("%0d bins never came out", transformed_bins.size());
			n_errors++;
		end

		$display("sent %0d bins, checked %0d under %0d response settings, %0d singular",
			n_sent, n_checked, n_settings, n_singular);
		$display("idling: none, sender only, receiver only, both; %0d errors", n_errors);
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
